### sv/iba_pkg.sv
// Shared types, constants and codes of the inode bitmap allocator.
// Used by the stream interface instances, the step unit and the top level.
package iba_pkg;

   // Storage shape
   localparam int MAX_GROUPS    = 8;
   localparam int MAX_PER_GROUP = 256;
   localparam int GROUP_BYTES   = (MAX_PER_GROUP + 7) / 8;
   localparam int STORE_BYTES   = MAX_GROUPS * GROUP_BYTES;
   localparam int TOTAL_MAX     = MAX_GROUPS * MAX_PER_GROUP;

   // Field and storage widths
   localparam int CMD_W    = 3;
   localparam int INO_W    = 12;
   localparam int GSEL_W   = 3;
   localparam int BIDX_W   = 5;
   localparam int BYTE_W   = 8;
   localparam int CNT_W    = 12;
   localparam int STAT_W   = 2;
   localparam int GCNT_W   = 9;
   localparam int IPG_W    = 9;
   localparam int NG_W     = 4;
   localparam int GIDX_W   = $clog2(MAX_GROUPS);
   localparam int ADDR_W   = $clog2(STORE_BYTES);
   localparam int NBYTES_W = 6;
   localparam int STEP_W   = 12;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;
   localparam logic [CSR_IDX_W-1:0] CSR_MOUNTED = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IPG     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GROUPS  = 2'd2;

   // Commands
   localparam logic [CMD_W-1:0] CMD_ALLOC      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_FREE       = 3'd1;
   localparam logic [CMD_W-1:0] CMD_LOAD_BYTE  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_LOAD_GROUP = 3'd3;
   localparam logic [CMD_W-1:0] CMD_LOAD_TOTAL = 3'd4;

   // Status codes
   localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOT_MOUNTED = 2'd1;
   localparam logic [STAT_W-1:0] ST_RANGE       = 2'd2;
   localparam logic [STAT_W-1:0] ST_NONE_FREE   = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [INO_W-1:0]  inode_number;
      logic [GSEL_W-1:0] group_sel;
      logic [BIDX_W-1:0] byte_index;
      logic [BYTE_W-1:0] byte_value;
      logic [CNT_W-1:0]  count_value;
   } req_word_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [INO_W-1:0]  allocated_inode;
      logic [CNT_W-1:0]  total_free;
   } rsp_word_type;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_INC,
      OP_SUB
   } step_op_type;

   typedef struct packed {
      step_op_type       op;
      logic [STEP_W-1:0] a;
      logic [STEP_W-1:0] b;
   } step_req_type;

   typedef struct packed {
      logic [STEP_W-1:0] result;
      logic              ge;
   } step_rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_A_GRP,
      S_A_RD,
      S_A_CHK,
      S_A_NUM,
      S_F_DIV,
      S_F_RD,
      S_F_WR,
      S_FINISH
   } state_type;

endpackage

### sv/iba_stream_if.sv
// Valid/ready stream channel carrying one payload word per handshake.
// Payload type is set per instance; no other dependencies.
interface iba_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### sv/iba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module iba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

### sv/iba_step_unit.sv
// Shared add/subtract/compare unit stepped by the allocator sequencer.
// Depends on iba_pkg for the request and response structs.
module iba_step_unit
   import iba_pkg::*;
(
   input  step_req_type step_req,
   output step_rsp_type step_rsp
);
   always_comb begin
      step_rsp.ge = (step_req.a >= step_req.b);
      case (step_req.op)
         OP_INC:  step_rsp.result = step_req.a + step_req.b + STEP_W'(1);
         OP_SUB:  step_rsp.result = step_req.a - step_req.b;
         default: step_rsp.result = step_req.a + step_req.b;
      endcase
   end
endmodule

### sv/inode_bitmap_allocator.sv
// Grouped first-fit inode bitmap allocator, one command at a time.
// Loads and rejected commands pass through decode to the result. Allocate adds one step per group
// check, a read and a check per bitmap byte (registered RAM data) and one step to form a granted number.
// Free takes one subtract-and-compare step per group passed, then a bitmap byte read and write.
// A new command is taken while the previous result waits in the output register.
// Reset clears counters and per-byte valid bits at once; no clearing pass; config returns to defaults.
module inode_bitmap_allocator
   import iba_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   iba_stream_if.sink            req_if,
   iba_stream_if.source          rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   state_type state_ff, state_in;

   logic              mounted_ff, mounted_in;
   logic [IPG_W-1:0]  ipg_ff, ipg_in;
   logic [NG_W-1:0]   groups_ff, groups_in;

   logic [GCNT_W-1:0]      gcnt_ff [MAX_GROUPS];
   logic [GCNT_W-1:0]      gcnt_in [MAX_GROUPS];
   logic [CNT_W-1:0]       total_ff, total_in;
   logic [STORE_BYTES-1:0] valid_ff, valid_in;

   req_word_type      req_ff, req_in;
   logic [NG_W-1:0]   g_ff, g_in;
   logic [BIDX_W-1:0] b_ff, b_in;
   logic [STEP_W-1:0] base_ff, base_in;
   logic [STEP_W-1:0] rem_ff, rem_in;
   logic [BYTE_W-1:0] local_ff, local_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic [INO_W-1:0]  granted_ff, granted_in;
   logic [ADDR_W-1:0] rd_addr_ff, rd_addr_in;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_data_ff, rsp_data_in;

   logic              ram_we, ram_re;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [BYTE_W-1:0] ram_wdata, ram_rdata;

   step_req_type step_req;
   step_rsp_type step_rsp;

   logic [IPG_W-1:0]    eff_ipg;
   logic [NG_W-1:0]     eff_ng;
   logic [NBYTES_W-1:0] nbytes;
   logic [IPG_W:0]      ipg_round;
   logic [BYTE_W-1:0]   rd_byte;
   logic [BYTE_W-1:0]   allowed;
   logic [BYTE_W-1:0]   free_bits;
   logic [2:0]          pick;
   logic                last_byte;
   logic [GIDX_W-1:0]   g_idx;
   logic                req_fire;

   iba_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STORE_BYTES)
   ) u_bitmap (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   iba_step_unit u_step (
      .step_req (step_req),
      .step_rsp (step_rsp)
   );

   // Effective configuration
   always_comb begin
      if (ipg_ff == '0) begin
         eff_ipg = IPG_W'(1);
      end else if (ipg_ff > IPG_W'(MAX_PER_GROUP)) begin
         eff_ipg = IPG_W'(MAX_PER_GROUP);
      end else begin
         eff_ipg = ipg_ff;
      end
      eff_ng    = (groups_ff > NG_W'(MAX_GROUPS)) ? NG_W'(MAX_GROUPS) : groups_ff;
      ipg_round = {1'b0, eff_ipg} + (IPG_W+1)'(7);
      nbytes    = ipg_round[IPG_W-1:3];
   end

   // Byte scan: bits past the group end count as used; take the lowest clear one
   always_comb begin
      rd_byte = valid_ff[rd_addr_ff] ? ram_rdata : '0;
      for (int i = 0; i < BYTE_W; i++) begin
         allowed[i] = ({1'b0, b_ff, 3'(i)} < eff_ipg);
      end
      free_bits = ~rd_byte & allowed;
      pick = '0;
      for (int i = BYTE_W - 1; i >= 0; i--) begin
         if (free_bits[i]) begin
            pick = 3'(i);
         end
      end
      last_byte = (({1'b0, b_ff} + NBYTES_W'(1)) >= nbytes);
      g_idx     = g_ff[GIDX_W-1:0];
   end

   assign req_if.ready = (state_ff == S_IDLE);
   assign req_fire     = req_if.valid && (state_ff == S_IDLE);
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      mounted_in   = mounted_ff;
      ipg_in       = ipg_ff;
      groups_in    = groups_ff;
      gcnt_in      = gcnt_ff;
      total_in     = total_ff;
      valid_in     = valid_ff;
      req_in       = req_ff;
      g_in         = g_ff;
      b_in         = b_ff;
      base_in      = base_ff;
      rem_in       = rem_ff;
      local_in     = local_ff;
      status_in    = status_ff;
      granted_in   = granted_ff;
      rd_addr_in   = rd_addr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = '0;
      ram_wdata    = '0;
      ram_re       = 1'b0;
      ram_raddr    = '0;
      step_req     = '{op: OP_ADD, a: base_ff, b: STEP_W'(eff_ipg)};

      if (csr_we) begin
         unique case (csr_index)
            CSR_MOUNTED: mounted_in = csr_wdata[0];
            CSR_IPG:     ipg_in     = csr_wdata[IPG_W-1:0];
            CSR_GROUPS:  groups_in  = csr_wdata[NG_W-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               req_in     = req_if.data;
               status_in  = ST_OK;
               granted_in = '0;
               state_in   = S_DECODE;
            end
         end

         S_DECODE: begin
            state_in = S_FINISH;
            case (req_ff.cmd)
               CMD_ALLOC: begin
                  if (!mounted_ff) begin
                     status_in = ST_NOT_MOUNTED;
                  end else begin
                     g_in     = '0;
                     base_in  = '0;
                     state_in = S_A_GRP;
                  end
               end
               CMD_FREE: begin
                  if (!mounted_ff || req_ff.inode_number == '0) begin
                     status_in = ST_NOT_MOUNTED;
                  end else begin
                     g_in     = '0;
                     rem_in   = req_ff.inode_number - INO_W'(1);
                     state_in = S_F_DIV;
                  end
               end
               CMD_LOAD_BYTE: begin
                  if (int'(req_ff.group_sel) >= MAX_GROUPS ||
                      int'(req_ff.byte_index) >= GROUP_BYTES) begin
                     status_in = ST_RANGE;
                  end else begin
                     ram_we    = 1'b1;
                     ram_waddr = {req_ff.group_sel, req_ff.byte_index};
                     ram_wdata = req_ff.byte_value;
                     valid_in[ram_waddr] = 1'b1;
                  end
               end
               CMD_LOAD_GROUP: begin
                  if (int'(req_ff.group_sel) >= MAX_GROUPS) begin
                     status_in = ST_RANGE;
                  end else if (req_ff.count_value > CNT_W'(MAX_PER_GROUP)) begin
                     gcnt_in[req_ff.group_sel] = GCNT_W'(MAX_PER_GROUP);
                  end else begin
                     gcnt_in[req_ff.group_sel] = req_ff.count_value[GCNT_W-1:0];
                  end
               end
               CMD_LOAD_TOTAL: begin
                  total_in = (req_ff.count_value > CNT_W'(TOTAL_MAX)) ?
                             CNT_W'(TOTAL_MAX) : req_ff.count_value;
               end
               default: ;
            endcase
         end

         S_A_GRP: begin
            if (g_ff >= eff_ng) begin
               status_in = ST_NONE_FREE;
               state_in  = S_FINISH;
            end else if (gcnt_ff[g_idx] == '0) begin
               // skip empty group, advance base by one group
               g_in    = g_ff + NG_W'(1);
               base_in = step_rsp.result;
            end else begin
               b_in     = '0;
               state_in = S_A_RD;
            end
         end

         S_A_RD: begin
            ram_re     = 1'b1;
            ram_raddr  = {g_idx, b_ff};
            rd_addr_in = ram_raddr;
            state_in   = S_A_CHK;
         end

         S_A_CHK: begin
            if (free_bits != '0) begin
               ram_we    = 1'b1;
               ram_waddr = rd_addr_ff;
               ram_wdata = rd_byte | (BYTE_W'(1) << pick);
               valid_in[rd_addr_ff] = 1'b1;
               if (total_ff != '0) begin
                  total_in = total_ff - CNT_W'(1);
               end
               if (gcnt_ff[g_idx] != '0) begin
                  gcnt_in[g_idx] = gcnt_ff[g_idx] - GCNT_W'(1);
               end
               local_in = {b_ff, pick};
               state_in = S_A_NUM;
            end else if (last_byte) begin
               g_in     = g_ff + NG_W'(1);
               base_in  = step_rsp.result;
               state_in = S_A_GRP;
            end else begin
               b_in     = b_ff + BIDX_W'(1);
               state_in = S_A_RD;
            end
         end

         S_A_NUM: begin
            step_req   = '{op: OP_INC, a: base_ff, b: STEP_W'(local_ff)};
            granted_in = step_rsp.result[INO_W-1:0];
            state_in   = S_FINISH;
         end

         S_F_DIV: begin
            // one subtract per group: quotient lands in g, remainder in rem
            step_req = '{op: OP_SUB, a: rem_ff, b: STEP_W'(eff_ipg)};
            if (g_ff >= eff_ng) begin
               status_in = ST_RANGE;
               state_in  = S_FINISH;
            end else if (step_rsp.ge) begin
               rem_in = step_rsp.result;
               g_in   = g_ff + NG_W'(1);
            end else begin
               state_in = S_F_RD;
            end
         end

         S_F_RD: begin
            ram_re     = 1'b1;
            ram_raddr  = {g_idx, rem_ff[BYTE_W-1:3]};
            rd_addr_in = ram_raddr;
            state_in   = S_F_WR;
         end

         S_F_WR: begin
            ram_we    = 1'b1;
            ram_waddr = rd_addr_ff;
            ram_wdata = rd_byte & ~(BYTE_W'(1) << rem_ff[2:0]);
            valid_in[rd_addr_ff] = 1'b1;
            total_in = (total_ff >= CNT_W'(TOTAL_MAX)) ?
                       CNT_W'(TOTAL_MAX) : total_ff + CNT_W'(1);
            gcnt_in[g_idx] = (gcnt_ff[g_idx] >= GCNT_W'(MAX_PER_GROUP)) ?
                             GCNT_W'(MAX_PER_GROUP) : gcnt_ff[g_idx] + GCNT_W'(1);
            state_in = S_FINISH;
         end

         S_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{status: status_ff, allocated_inode: granted_ff,
                                total_free: total_ff};
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mounted_ff   <= 1'b0;
         ipg_ff       <= IPG_W'(MAX_PER_GROUP);
         groups_ff    <= NG_W'(1);
         total_ff     <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_GROUPS; i++) begin
            gcnt_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         mounted_ff   <= mounted_in;
         ipg_ff       <= ipg_in;
         groups_ff    <= groups_in;
         total_ff     <= total_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         gcnt_ff      <= gcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      g_ff        <= g_in;
      b_ff        <= b_in;
      base_ff     <= base_in;
      rem_ff      <= rem_in;
      local_ff    <= local_in;
      status_ff   <= status_in;
      granted_ff  <= granted_in;
      rd_addr_ff  <= rd_addr_in;
      rsp_data_ff <= rsp_data_in;
   end
endmodule
